@@ rtl/core/msbbr_pkg.sv @@
// Package of constants and types shared by the MSB-first bit reader files.
package msbbr_pkg;

  // Store geometry and field widths.
  localparam int STORE_BYTES   = 4096;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int BYTE_W        = 8;
  localparam int BIT_POS_W     = $clog2(BYTE_W);
  localparam int TAKE_W        = BIT_POS_W + 1;
  localparam int MAX_READ_BITS = 32;
  localparam int COUNT_W       = 6;
  localparam int VALUE_W       = 32;
  localparam int FIELD_ADDR_W  = 12;

  // Command codes carried by an input item.
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Control from the sequencer to the bit gatherer.
  typedef struct packed {
    logic               load;
    logic [COUNT_W-1:0] count;
    logic               step;
  } gather_ctl_t;

  // Status from the bit gatherer back to the sequencer.
  typedef struct packed {
    logic [TAKE_W-1:0] take;
    logic              last;
  } gather_stat_t;

endpackage

@@ rtl/core/msbbr_channels.sv @@
// Channel interfaces for the input items and the result items of the bit reader.
interface msbbr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [msbbr_pkg::FIELD_ADDR_W-1:0]  byte_address;
  logic [msbbr_pkg::BYTE_W-1:0]        byte_data;
  logic [msbbr_pkg::COUNT_W-1:0]       bits_requested;

  modport source (output valid, command, byte_address, byte_data, bits_requested,
                  input ready);
  modport sink (input valid, command, byte_address, byte_data, bits_requested,
                output ready);
endinterface

interface msbbr_out_if;
  logic                          valid;
  logic                          ready;
  logic [msbbr_pkg::VALUE_W-1:0] bits_value;

  modport source (output valid, bits_value, input ready);
  modport sink (input valid, bits_value, output ready);
endinterface

@@ rtl/core/msb_first_bit_reader_unit.sv @@
// Top level of the MSB-first bit reader: byte store, read cursor and sequencer.
//
// Usage: input items arrive on in_chan (valid/ready). A store item (command 0)
// writes byte_data at byte_address into the 4096-byte store and gives no result.
// A read item (command 1) takes bits_requested bits (saturated at 32) from the
// cursor, most significant bit of each byte first, and returns them
// right-aligned as one result item on out_chan; the cursor then moves on,
// wrapping at the end of the store. A count of zero returns zero.
// Steps: a store item is written as it is accepted. A read item, once accepted,
// takes one step for each stored byte it touches (at least one, and up to five
// for a 32-bit read that starts mid-byte), set by the single read port of the
// byte store, which returns one byte a cycle with registered read data.
// A new item is accepted once the previous read has handed its result to the
// output register. When the receiver stalls, the result waits in the output
// register; store items are still taken, and a following read holds on its
// last byte until the register is free.
// Reset clears the cursor and the sequencer; the store contents are undefined
// until written.
module msb_first_bit_reader_unit (
  input  logic             clk,
  input  logic             rst_n,
  msbbr_in_if.sink         in_chan,
  msbbr_out_if.source      out_chan
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                               state_r;
  logic                               state_nxt;
  logic [msbbr_pkg::ADDR_W-1:0]       cursor_byte_r;
  logic [msbbr_pkg::ADDR_W-1:0]       cursor_byte_nxt;
  logic [msbbr_pkg::BIT_POS_W-1:0]    cursor_bit_r;
  logic [msbbr_pkg::BIT_POS_W-1:0]    cursor_bit_nxt;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [msbbr_pkg::VALUE_W-1:0]      out_bits_r;

  logic [msbbr_pkg::BYTE_W-1:0]       mem [msbbr_pkg::STORE_BYTES];
  logic [msbbr_pkg::BYTE_W-1:0]       rd_data_r;
  logic                               rd_en;
  logic [msbbr_pkg::ADDR_W-1:0]       rd_addr;
  logic                               wr_en;
  logic [msbbr_pkg::ADDR_W-1:0]       wr_addr;

  logic                               accept;
  logic                               accept_read;
  logic                               out_free;
  logic                               run_step;
  logic [msbbr_pkg::ADDR_W-1:0]       next_byte;
  logic [msbbr_pkg::TAKE_W-1:0]       bit_sum;
  logic [msbbr_pkg::COUNT_W-1:0]      count_sat;
  logic [msbbr_pkg::VALUE_W-1:0]      value_nxt;
  msbbr_pkg::gather_ctl_t             gctl;
  msbbr_pkg::gather_stat_t            gstat;

  // Handshake and item decode.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign accept_read   = accept && (in_chan.command == msbbr_pkg::CMD_READ);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign run_step      = (state_r == ST_RUN) && (!gstat.last || out_free);

  // Counts above the maximum saturate.
  assign count_sat = (in_chan.bits_requested > msbbr_pkg::COUNT_W'(msbbr_pkg::MAX_READ_BITS))
                   ? msbbr_pkg::COUNT_W'(msbbr_pkg::MAX_READ_BITS)
                   : in_chan.bits_requested;

  // Following byte index, wrapping at the end of the store.
  assign next_byte = (cursor_byte_r == msbbr_pkg::ADDR_W'(msbbr_pkg::STORE_BYTES - 1))
                   ? '0 : cursor_byte_r + msbbr_pkg::ADDR_W'(1);

  // Memory port control: read the cursor byte on accepting a read, prefetch the
  // next byte whenever the current one is used up and more bits are still wanted.
  always_comb begin
    wr_en   = accept && (in_chan.command == msbbr_pkg::CMD_STORE);
    wr_addr = msbbr_pkg::ADDR_W'(in_chan.byte_address);
    rd_en   = accept_read || (run_step && !gstat.last);
    rd_addr = accept_read ? cursor_byte_r : next_byte;
  end

  // Byte store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_chan.byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Gatherer control.
  always_comb begin
    gctl.load  = accept_read;
    gctl.count = count_sat;
    gctl.step  = run_step;
  end

  msbbr_gather u_gather (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (gctl),
    .bit_pos   (cursor_bit_r),
    .rd_data   (rd_data_r),
    .stat      (gstat),
    .value_nxt (value_nxt)
  );

  // Sequencer, cursor and output register next values.
  always_comb begin
    state_nxt       = state_r;
    cursor_byte_nxt = cursor_byte_r;
    cursor_bit_nxt  = cursor_bit_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    bit_sum         = {1'b0, cursor_bit_r} + gstat.take;
    case (state_r)
      ST_IDLE: begin
        if (accept_read) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_step) begin
          if (bit_sum[msbbr_pkg::BIT_POS_W]) begin
            cursor_bit_nxt  = '0;
            cursor_byte_nxt = next_byte;
          end else begin
            cursor_bit_nxt = bit_sum[msbbr_pkg::BIT_POS_W-1:0];
          end
          if (gstat.last) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cursor_byte_r <= '0;
      cursor_bit_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cursor_byte_r <= cursor_byte_nxt;
      cursor_bit_r  <= cursor_bit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result value is captured as the last byte of a read is merged.
  always_ff @(posedge clk) begin
    if (run_step && gstat.last) begin
      out_bits_r <= value_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.bits_value = out_bits_r;

`ifndef ASSERT_OFF
  // A byte that is used up and is not the last one leaves the cursor on a byte edge.
  a_byte_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (run_step && !gstat.last) |=> (cursor_bit_r == '0))
    else $error("cursor not on a byte edge after a full byte was used");

  // A new result only ever comes from the read sequence.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RUN))
    else $error("result raised outside a read sequence");

  // The last step of a read waits while the output register is still occupied.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && gstat.last && !out_free) |=> (state_r == ST_RUN))
    else $error("read finished while the output register was occupied");
`endif

endmodule

@@ rtl/core/msbbr_gather.sv @@
// Bit gatherer: takes bits from one stored byte a cycle into the accumulator while stepped.
module msbbr_gather (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msbbr_pkg::gather_ctl_t              ctl,
  input  logic [msbbr_pkg::BIT_POS_W-1:0]     bit_pos,
  input  logic [msbbr_pkg::BYTE_W-1:0]        rd_data,
  output msbbr_pkg::gather_stat_t             stat,
  output logic [msbbr_pkg::VALUE_W-1:0]       value_nxt
);

  logic [msbbr_pkg::COUNT_W-1:0] rem_r;
  logic [msbbr_pkg::COUNT_W-1:0] rem_nxt;
  logic [msbbr_pkg::VALUE_W-1:0] acc_r;
  logic [msbbr_pkg::VALUE_W-1:0] acc_nxt;
  logic [msbbr_pkg::TAKE_W-1:0]  avail;
  logic [msbbr_pkg::TAKE_W-1:0]  take;
  logic [msbbr_pkg::TAKE_W-1:0]  shift;
  logic [msbbr_pkg::BYTE_W-1:0]  mask;
  logic [msbbr_pkg::BYTE_W-1:0]  chunk;
  logic                          last;

  // Bits left in the current byte and how many of them this step takes.
  always_comb begin
    avail = msbbr_pkg::TAKE_W'(msbbr_pkg::BYTE_W) - {1'b0, bit_pos};
    last  = rem_r <= msbbr_pkg::COUNT_W'(avail);
    take  = last ? msbbr_pkg::TAKE_W'(rem_r) : avail;
    shift = avail - take;
    mask  = msbbr_pkg::BYTE_W'((9'd1 << take) - 9'd1);
    chunk = (rd_data >> shift) & mask;
  end

  // Append the chunk below the bits gathered so far.
  always_comb begin
    acc_nxt   = (acc_r << take) | msbbr_pkg::VALUE_W'(chunk);
    rem_nxt   = rem_r - msbbr_pkg::COUNT_W'(take);
    value_nxt = acc_nxt;
    stat.take = take;
    stat.last = last;
  end

  // Remaining count is control state; the accumulator is cleared on load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (ctl.load) begin
      rem_r <= ctl.count;
    end else if (ctl.step) begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

endmodule
